@@ hw/rtl/lps_pkg.sv @@
// shared types and constants of the log level prefix stripper
package lps_pkg;

	localparam int PREFIX_DIGITS_MAX_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [3:0] DIGIT_HI_NIBBLE = 4'h3;
	localparam logic [3:0] LEVEL_DIGIT_MAX = 4'd7;
	localparam logic [2:0] LEVEL_RESET = 3'd4;

	typedef enum logic [2:0] {
		PH_START  = 3'b001,
		PH_DIGITS = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef enum logic {
		CMD_BYTE   = 1'b0,
		CMD_REPLAY = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] ch;
		logic [2:0] level;
	} cmd_t;

endpackage

@@ hw/rtl/lps_stream_if.sv @@
// byte input and result output channel interfaces
interface lps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

interface lps_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [2:0] out_level;
	logic       line_end;
	logic       last;

	modport source (output valid, output out_char, output out_level, output line_end,
		output last, input ready);
	modport sink (input valid, input out_char, input out_level, input line_end,
		input last, output ready);
endinterface

@@ hw/rtl/lps_front.sv @@
// front end: prefix parser that classifies each byte and pushes an emit command for plain and replay bytes
module lps_front #(
	parameter int PREFIX_DIGITS_MAX = lps_pkg::PREFIX_DIGITS_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [2:0]                           cfg_wdata,
	lps_in_if.sink                               byte_in,
	input  logic                                 full,
	output logic                                 push,
	output lps_pkg::cmd_t                        push_cmd,
	output logic [$clog2(PREFIX_DIGITS_MAX+1)-1:0] push_cnt,
	output logic [PREFIX_DIGITS_MAX*4-1:0]       push_digits
);
	import lps_pkg::*;

	localparam int CW = $clog2(PREFIX_DIGITS_MAX + 1);
	localparam int IW = $clog2(PREFIX_DIGITS_MAX);

	phase_t          phase_q, phase_n;
	logic [CW-1:0]   cnt_q, cnt_n;
	logic [2:0]      acc_q, acc_n;
	logic [2:0]      line_level_q, line_level_n;
	logic [2:0]      default_level_q;
	logic [3:0]      held_q [PREFIX_DIGITS_MAX];
	logic            wr_en;
	logic            accept;
	logic            push_c;
	logic [7:0]      ch;
	logic            is_digit;
	logic            is_nl;
	phase_t          after_byte;

	assign byte_in.ready = !full;
	assign accept = byte_in.valid && byte_in.ready;
	assign ch = byte_in.in_char;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_nl = (ch == CH_NL);
	assign after_byte = is_nl ? PH_START : PH_BODY;
	assign push = accept && push_c;
	assign push_cnt = cnt_q;

	always_comb begin
		for (int i = 0; i < PREFIX_DIGITS_MAX; i++) begin
			push_digits[i*4 +: 4] = held_q[i];
		end
	end

	always_comb begin
		phase_n = phase_q;
		cnt_n = cnt_q;
		acc_n = acc_q;
		line_level_n = line_level_q;
		wr_en = 1'b0;
		push_c = 1'b0;
		push_cmd.kind = CMD_BYTE;
		push_cmd.ch = ch;
		push_cmd.level = line_level_q;
		case (phase_q)
			PH_START: begin
				if (ch == CH_LT) begin
					phase_n = PH_DIGITS;
					cnt_n = '0;
					acc_n = '0;
				end else begin
					push_c = 1'b1;
					push_cmd.level = default_level_q;
					line_level_n = default_level_q;
					phase_n = after_byte;
				end
			end
			PH_DIGITS: begin
				if (is_digit && (cnt_q < CW'(PREFIX_DIGITS_MAX))) begin
					wr_en = 1'b1;
					cnt_n = cnt_q + CW'(1);
					acc_n = {acc_q[1:0], 1'b0} + ch[2:0];
				end else if ((ch == CH_GT) && (cnt_q != '0) &&
						!((cnt_q == CW'(1)) && (held_q[0] > LEVEL_DIGIT_MAX))) begin
					line_level_n = acc_q;
					cnt_n = '0;
					acc_n = '0;
					phase_n = PH_BODY;
				end else begin
					push_c = 1'b1;
					push_cmd.kind = CMD_REPLAY;
					push_cmd.level = default_level_q;
					line_level_n = default_level_q;
					cnt_n = '0;
					acc_n = '0;
					phase_n = after_byte;
				end
			end
			PH_BODY: begin
				push_c = 1'b1;
				phase_n = after_byte;
			end
			default: begin
				phase_n = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q <= '0;
			acc_q <= '0;
			line_level_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q <= cnt_n;
			acc_q <= acc_n;
			line_level_q <= line_level_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_level_q <= LEVEL_RESET;
		end else if (cfg_we) begin
			default_level_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			held_q[cnt_q[IW-1:0]] <= ch[3:0];
		end
	end

endmodule

@@ hw/rtl/lps_queue.sv @@
// short command queue between parser and emitter
module lps_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	import lps_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full = (count_q == NW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/lps_back.sv @@
// back end: emits plain bytes and replays failed prefixes byte by byte
module lps_back #(
	parameter int PREFIX_DIGITS_MAX = lps_pkg::PREFIX_DIGITS_MAX_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              head_valid,
	input  logic [$clog2(PREFIX_DIGITS_MAX+1)+PREFIX_DIGITS_MAX*4+$bits(lps_pkg::cmd_t)-1:0]
		head_data,
	output logic                                              pop,
	lps_out_if.source                                         result_out
);
	import lps_pkg::*;

	localparam int CW = $clog2(PREFIX_DIGITS_MAX + 1);
	localparam int IW = $clog2(PREFIX_DIGITS_MAX);
	localparam int PW = $clog2(PREFIX_DIGITS_MAX + 2);
	localparam int DW = PREFIX_DIGITS_MAX * 4;

	cmd_t            head_cmd;
	logic [CW-1:0]   head_cnt;
	logic [DW-1:0]   head_digits;
	logic [PW-1:0]   pos_q;
	logic [PW-1:0]   pos_m1;
	logic [PW-1:0]   end_pos;
	logic            is_rep;
	logic            at_end;
	logic            fire;
	logic [7:0]      char_c;

	assign {head_cnt, head_digits, head_cmd} = head_data;
	assign is_rep = (head_cmd.kind == CMD_REPLAY);
	assign end_pos = PW'(head_cnt) + PW'(1);
	assign at_end = !is_rep || (pos_q == end_pos);
	assign pos_m1 = pos_q - PW'(1);

	always_comb begin
		if (!is_rep || at_end) begin
			char_c = head_cmd.ch;
		end else if (pos_q == '0) begin
			char_c = CH_LT;
		end else begin
			char_c = {DIGIT_HI_NIBBLE, head_digits[pos_m1[IW-1:0]*4 +: 4]};
		end
	end

	assign result_out.valid = head_valid;
	assign result_out.out_char = char_c;
	assign result_out.out_level = head_cmd.level;
	assign result_out.line_end = (char_c == CH_NL);
	assign result_out.last = at_end;

	assign fire = result_out.valid && result_out.ready;
	assign pop = fire && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (pop) begin
			pos_q <= '0;
		end else if (fire) begin
			pos_q <= pos_q + PW'(1);
		end
	end

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && is_rep |-> pos_q <= end_pos)
		else $error("replay position past end of command");
	a_plain_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !is_rep |-> pos_q == '0)
		else $error("plain byte command with nonzero replay position");
	a_replay_continues: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !at_end |=> result_out.valid)
		else $error("replay interrupted before its last item");
`endif

endmodule

@@ hw/rtl/log_level_prefix_stripper.sv @@
// top level of the log level prefix stripper
//
// channel     dir  fields                                   handshake
// byte_in     in   in_char[7:0]                             valid/ready
// result_out  out  out_char[7:0] out_level[2:0] line_end last valid/ready
// cfg         in   cfg_wdata[2:0] (default level)           cfg_we, no wait
//
// one input item per cycle; a plain byte leaves one result, a prefix byte none
// a failed prefix replays up to PREFIX_DIGITS_MAX+2 results, one per cycle unless stalled
// byte_in stalls only when the command queue between parser and emitter is full
// reset clears parser state and the queue; default level resets to 4
module log_level_prefix_stripper #(
	parameter int PREFIX_DIGITS_MAX = lps_pkg::PREFIX_DIGITS_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	lps_in_if.sink     byte_in,
	lps_out_if.source  result_out
);
	import lps_pkg::*;

	localparam int CW = $clog2(PREFIX_DIGITS_MAX + 1);
	localparam int DW = PREFIX_DIGITS_MAX * 4;
	localparam int QW = CW + DW + $bits(cmd_t);

	logic          push;
	cmd_t          push_cmd;
	logic [CW-1:0] push_cnt;
	logic [DW-1:0] push_digits;
	logic          full;
	logic          pop;
	logic          head_valid;
	logic [QW-1:0] head_data;

	lps_front #(.PREFIX_DIGITS_MAX(PREFIX_DIGITS_MAX)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.byte_in     (byte_in),
		.full        (full),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_cnt    (push_cnt),
		.push_digits (push_digits)
	);

	lps_queue #(.WIDTH(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_cnt, push_digits, push_cmd}),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	lps_back #(.PREFIX_DIGITS_MAX(PREFIX_DIGITS_MAX)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.result_out (result_out)
	);

endmodule

@@ tb/log_level_prefix_stripper_test.sv @@
// testbench of the log level prefix stripper: directed table, then random log lines checked
`timescale 1ns / 1ps

module log_level_prefix_stripper_test;
	import lps_pkg::*;

	localparam int DIGITS_MAX = PREFIX_DIGITS_MAX_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_BYTES = 72;

	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] level;
		logic       line_end;
		logic       last;
	} result_t;

	typedef struct {
		logic [7:0] ch;
		bit         typed;
		result_t    want;
	} stim_row_t;

	typedef struct {
		bit      typed;
		result_t want;
	} row_note_t;

	localparam result_t NO_RES = '0;

	// directed rows; typed expectations only where the answer is obvious
	stim_row_t directed_rows [0:25] = '{
		'{8'h41, 1'b1, '{8'h41, LEVEL_RESET, 1'b0, 1'b1}},
		'{CH_NL, 1'b1, '{CH_NL, LEVEL_RESET, 1'b1, 1'b1}},
		'{CH_LT, 1'b0, NO_RES},
		'{CH_ZERO + 8'd7, 1'b0, NO_RES},
		'{CH_GT, 1'b0, NO_RES},
		'{8'hFF, 1'b1, '{8'hFF, 3'd7, 1'b0, 1'b1}},
		'{8'h00, 1'b1, '{8'h00, 3'd7, 1'b0, 1'b1}},
		'{CH_NL, 1'b1, '{CH_NL, 3'd7, 1'b1, 1'b1}},
		'{CH_LT, 1'b0, NO_RES},
		'{CH_GT, 1'b0, NO_RES},
		'{CH_NL, 1'b0, NO_RES},
		'{CH_LT, 1'b0, NO_RES},
		'{CH_NINE, 1'b0, NO_RES},
		'{CH_GT, 1'b0, NO_RES},
		'{CH_NL, 1'b0, NO_RES},
		'{CH_LT, 1'b0, NO_RES},
		'{CH_ZERO, 1'b0, NO_RES},
		'{CH_NINE, 1'b0, NO_RES},
		'{CH_GT, 1'b0, NO_RES},
		'{CH_LT, 1'b0, NO_RES},
		'{CH_NL, 1'b0, NO_RES},
		'{CH_LT, 1'b0, NO_RES},
		'{8'h45, 1'b0, NO_RES},
		'{CH_NL, 1'b0, NO_RES},
		'{CH_LT, 1'b0, NO_RES},
		'{CH_NL, 1'b0, NO_RES}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	lps_in_if  byte_ch ();
	lps_out_if result_ch ();

	log_level_prefix_stripper #(
		.PREFIX_DIGITS_MAX(DIGITS_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_in(byte_ch),
		.result_out(result_ch)
	);

	// prefix parser state mirrored here
	phase_t     parse_phase;
	int         digit_cnt;
	logic [3:0] digit_buf [DIGITS_MAX];
	logic [2:0] level_acc;
	logic [2:0] line_level;
	logic [2:0] console_default;

	result_t   stripped [$];
	result_t   due_bytes [$];
	row_note_t row_notes [$];

	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int bytes_out;
	int mismatches;
	int cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void emit(logic [7:0] c);
		stripped.push_back('{c, line_level, c == CH_NL, 1'b0});
	endfunction

	function automatic void body_char(logic [7:0] c);
		emit(c);
		parse_phase = (c == CH_NL) ? PH_START : PH_BODY;
	endfunction

	function automatic void fail_prefix(logic [7:0] c);
		line_level = console_default;
		emit(CH_LT);
		for (int i = 0; i < digit_cnt; i++)
			emit({DIGIT_HI_NIBBLE, digit_buf[i]});
		digit_cnt = 0;
		level_acc = '0;
		body_char(c);
	endfunction

	function automatic void strip_byte(logic [7:0] c);
		logic [3:0] d;
		d = c[3:0];
		stripped.delete();
		case (parse_phase)
			PH_START: begin
				if (c == CH_LT) begin
					parse_phase = PH_DIGITS;
					digit_cnt = 0;
					level_acc = '0;
				end else begin
					line_level = console_default;
					body_char(c);
				end
			end
			PH_DIGITS: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					if (digit_cnt < DIGITS_MAX) begin
						digit_buf[digit_cnt] = d;
						digit_cnt++;
						level_acc = 3'((int'(level_acc) * 10 + int'(d)) % 8);
					end else begin
						fail_prefix(c);
					end
				end else if (c == CH_GT && digit_cnt > 0 &&
						!(digit_cnt == 1 && digit_buf[0] > LEVEL_DIGIT_MAX)) begin
					line_level = level_acc;
					digit_cnt = 0;
					level_acc = '0;
					parse_phase = PH_BODY;
				end else begin
					fail_prefix(c);
				end
			end
			default: body_char(c);
		endcase
		if (stripped.size() > 0)
			stripped[stripped.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what, result_t got, result_t want);
		mismatches++;
		$display("mismatch at cycle %0d (%s): got ch=%h lvl=%0d nl=%0b last=%0b,"
			, cycle_count, what, got.ch, got.level, got.line_end, got.last,
			" want ch=%h lvl=%0d nl=%0b last=%0b",
			want.ch, want.level, want.line_end, want.last);
	endtask

	task automatic push_byte(logic [7:0] c, bit typed = 1'b0, result_t want = '0);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		row_notes.push_back('{typed, want});
		byte_ch.valid <= 1'b1;
		byte_ch.in_char <= c;
		bytes_sent++;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
	endtask

	task automatic settle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_default(logic [2:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		console_default = v;
	endtask

	// prefixed lines, well-formed or with broken prefixes, and raw noise
	task automatic gen_sequence();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 80) begin
			push_byte(CH_LT);
			n = ($urandom_range(9) == 0) ? $urandom_range(DIGITS_MAX + 2) : $urandom_range(3);
			for (int i = 0; i < n; i++)
				push_byte(CH_ZERO + 8'($urandom_range(9)));
			if (kind < 60)
				push_byte(CH_GT);
			else
				push_byte(8'($urandom_range(255)));
			n = $urandom_range(8);
			for (int i = 0; i < n; i++)
				push_byte(8'($urandom_range(255)));
			if ($urandom_range(3) != 0)
				push_byte(CH_NL);
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				push_byte(($urandom_range(2) == 0) ? CH_NL : 8'($urandom_range(255)));
		end
	endtask

	always @(posedge clk) begin
		row_note_t note;
		result_t   got;
		result_t   want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end else if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				note = row_notes.pop_front();
				strip_byte(byte_ch.in_char);
				if (note.typed)
					due_bytes.push_back(note.want);
				else
					foreach (stripped[i]) due_bytes.push_back(stripped[i]);
			end
			if (result_ch.valid && result_ch.ready) begin
				got = '{result_ch.out_char, result_ch.out_level, result_ch.line_end,
					result_ch.last};
				bytes_out++;
				if (due_bytes.size() == 0) begin
					report_mismatch("no item expected", got, NO_RES);
				end else begin
					want = due_bytes.pop_front();
					if (got != want)
						report_mismatch("field", got, want);
				end
			end
		end
	end

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	initial begin
		int         send_pct [4] = '{0, 66, 0, 23};
		int         stall_pct [4] = '{0, 0, 66, 23};
		logic [2:0] levels [4];
		int         target;
		levels = '{3'd7, 3'd0, 3'($urandom_range(7)), 3'd2};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.in_char = '0;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		bytes_out = 0;
		mismatches = 0;
		cycle_count = 0;
		parse_phase = PH_START;
		digit_cnt = 0;
		level_acc = '0;
		line_level = '0;
		console_default = LEVEL_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < 4; p++) begin
			set_default(levels[p]);
			send_idle_pct = send_pct[p];
			recv_stall_pct = stall_pct[p];
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target)
				gen_sequence();
		end
		settle();

		$display("%0d bytes in, %0d bytes out, %0d mismatches", bytes_sent, bytes_out,
			mismatches);
		$display("covered prefixed, broken and plain lines under four idle mixes");
		if (mismatches == 0 && due_bytes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/lps_pkg.sv
hw/rtl/lps_stream_if.sv
hw/rtl/lps_front.sv
hw/rtl/lps_queue.sv
hw/rtl/lps_back.sv
hw/rtl/log_level_prefix_stripper.sv
tb/log_level_prefix_stripper_test.sv
